FILE: rtl/core/tcdr_pkg.sv
// Shared types and constants for the text cell diff refresh block.
// Grid geometry, command encoding between front and back, cursor helper.
// No dependencies.
`default_nettype none

package tcdr_pkg;

  localparam int ROWS        = 4;
  localparam int COLS        = 16;
  localparam int CELLS       = ROWS * COLS;
  localparam int ADDR_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W       = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // command queue, depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] NUL_CODE     = 8'h00;
  localparam logic [7:0] SAT_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_PUTC   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } cmd_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == SAT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcdr_front.sv
// Front end: accepts host transactions, tracks the cursor and turns them
// into cell write / clear / update commands. Depends on tcdr_pkg.
`default_nettype none

module tcdr_front import tcdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] start_col_i,
  input  logic [7:0] start_row_i,
  input  logic [7:0] char_in_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  logic [7:0] cursor_col_q, cursor_col_d;
  logic [7:0] cursor_row_q, cursor_row_d;
  logic [7:0] line_start_q, line_start_d;
  logic              accept;
  logic              in_grid;
  logic [ADDR_W-1:0] cell_addr;
  kind_e             kind;

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign in_grid   = (cursor_col_q < 8'(COLS)) && (cursor_row_q < 8'(ROWS));
  assign cell_addr = ADDR_W'(ADDR_W'(cursor_row_q[ROW_W-1:0]) * ADDR_W'(COLS))
                   + ADDR_W'(cursor_col_q[COL_W-1:0]);

  always_comb begin
    cursor_col_d    = cursor_col_q;
    cursor_row_d    = cursor_row_q;
    line_start_d    = line_start_q;
    q_push_o        = 1'b0;
    q_cmd_o.op      = OP_WRITE;
    q_cmd_o.addr    = cell_addr;
    q_cmd_o.data    = char_in_i;
    if (accept) begin
      case (kind)
        KIND_START: begin
          cursor_col_d = start_col_i;
          line_start_d = start_col_i;
          cursor_row_d = start_row_i;
        end
        KIND_PUTC: begin
          if (char_in_i == NUL_CODE) begin
            // string terminator, no effect
          end else if (char_in_i == NEWLINE_CODE) begin
            cursor_row_d = sat_inc(cursor_row_q);
            cursor_col_d = line_start_q;
          end else begin
            q_push_o     = in_grid;
            cursor_col_d = sat_inc(cursor_col_q);
          end
        end
        KIND_CLEAR: begin
          q_push_o   = 1'b1;
          q_cmd_o.op = OP_CLEAR;
        end
        KIND_UPDATE: begin
          q_push_o   = 1'b1;
          q_cmd_o.op = OP_UPDATE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      line_start_q <= '0;
    end else begin
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      line_start_q <= line_start_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcdr_cmd_fifo.sv
// Short command queue between front end and back end.
// Depends on tcdr_pkg for cmd_t and depth.
`default_nettype none

module tcdr_cmd_fifo import tcdr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("command queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/tcdr_back.sv
// Back end: owns the text and shadow cell memories, applies cell writes and
// clears, and runs the dirty-cell scan for updates. Depends on tcdr_pkg.
`default_nettype none

module tcdr_back import tcdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] cell_col_o,
  output logic [1:0] cell_row_o,
  output logic [7:0] char_code_o,
  output logic [7:0] glyph_index_o,
  output logic [6:0] pixel_column_o,
  output logic [2:0] top_page_o,
  output logic       last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_FLUSH
  } state_e;

  state_e state_q;

  logic [7:0] text_mem   [CELLS];
  logic [7:0] shadow_mem [CELLS];
  logic [CELLS-1:0] text_vld_q;
  logic [CELLS-1:0] shadow_vld_q;

  logic [7:0] text_rd_q;
  logic [7:0] shadow_rd_q;
  logic       text_rv_q;
  logic       shadow_rv_q;

  logic [ADDR_W-1:0] addr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  found_q;

  // one-deep hold of the latest changed cell, so last can be known
  logic             pend_vld_q;
  logic [COL_W-1:0] pend_col_q;
  logic [ROW_W-1:0] pend_row_q;
  logic [7:0]       pend_char_q;

  logic             out_valid_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;

  logic [7:0] cur_cell;
  logic [7:0] cur_shown;
  logic       diff;
  logic       out_free;
  logic       hold;
  logic       scan_last;
  logic       cap_hit;
  logic       text_we;
  logic       shadow_we;
  logic       out_load;

  assign cur_cell  = text_rv_q ? text_rd_q : SPACE_CODE;
  assign cur_shown = shadow_rv_q ? shadow_rd_q : 8'h00;
  assign diff      = (cur_cell != cur_shown);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hold      = diff && pend_vld_q && !out_free;
  assign scan_last = (addr_q == ADDR_W'(CELLS - 1));
  assign cap_hit   = (found_q == CNT_W'(MAX_RESULTS - 1));

  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign text_we   = q_pop_o && (q_cmd_i.op == OP_WRITE);
  assign shadow_we = (state_q == ST_CMP) && diff && !hold;

  // output register takes a new transaction this cycle
  assign out_load  = ((state_q == ST_CMP) && diff && !hold && pend_vld_q)
                   || ((state_q == ST_FLUSH) && out_free);

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[q_cmd_i.addr] <= q_cmd_i.data;
    end
    if (shadow_we) begin
      shadow_mem[addr_q] <= cur_cell;
    end
    if (state_q == ST_RD) begin
      text_rd_q   <= text_mem[addr_q];
      shadow_rd_q <= shadow_mem[addr_q];
      text_rv_q   <= text_vld_q[addr_q];
      shadow_rv_q <= shadow_vld_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      text_vld_q   <= '0;
      shadow_vld_q <= '0;
      addr_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      found_q      <= '0;
      pend_vld_q   <= 1'b0;
      pend_col_q   <= '0;
      pend_row_q   <= '0;
      pend_char_q  <= '0;
      out_valid_q  <= 1'b0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            case (q_cmd_i.op)
              OP_WRITE:  text_vld_q[q_cmd_i.addr] <= 1'b1;
              OP_CLEAR:  text_vld_q <= '0;
              OP_UPDATE: begin
                addr_q  <= '0;
                col_q   <= '0;
                row_q   <= '0;
                found_q <= '0;
                state_q <= ST_RD;
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!hold) begin
            if (diff) begin
              shadow_vld_q[addr_q] <= 1'b1;
              if (pend_vld_q) begin
                out_valid_q <= 1'b1;
                out_col_q   <= pend_col_q;
                out_row_q   <= pend_row_q;
                out_char_q  <= pend_char_q;
                out_last_q  <= 1'b0;
              end
              pend_vld_q  <= 1'b1;
              pend_col_q  <= col_q;
              pend_row_q  <= row_q;
              pend_char_q <= cur_cell;
              found_q     <= found_q + CNT_W'(1);
            end
            if ((diff && cap_hit) || scan_last) begin
              state_q <= (diff || pend_vld_q) ? ST_FLUSH : ST_IDLE;
            end else begin
              addr_q <= addr_q + ADDR_W'(1);
              if (col_q == COL_W'(COLS - 1)) begin
                col_q <= '0;
                row_q <= row_q + ROW_W'(1);
              end else begin
                col_q <= col_q + COL_W'(1);
              end
              state_q <= ST_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_col_q   <= pend_col_q;
            out_row_q   <= pend_row_q;
            out_char_q  <= pend_char_q;
            out_last_q  <= 1'b1;
            pend_vld_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_col_o     = 4'(out_col_q);
  assign cell_row_o     = 2'(out_row_q);
  assign char_code_o    = out_char_q;
  assign glyph_index_o  = out_char_q - SPACE_CODE;
  assign pixel_column_o = 7'(out_col_q) << 3;
  assign top_page_o     = 3'(out_row_q) << 1;
  assign last_o         = out_last_q;

  a_flush_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> pend_vld_q)
    else $error("flush without a pending cell");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_vld_q)
    else $error("pending cell left behind after scan");

  a_found_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= CNT_W'(MAX_RESULTS))
    else $error("scan emitted more cells than the cap");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE && !pend_vld_q)
    else $error("command popped while scan busy");

endmodule

`default_nettype wire

FILE: rtl/core/text_cell_diff_refresh.sv
// Top level of the text cell diff refresh block.
// Instantiates tcdr_front, tcdr_cmd_fifo and tcdr_back; uses tcdr_pkg.
//
// Keeps a ROWS x COLS character grid plus a shadow of what the panel shows.
// Start-print, print-character and clear transactions are taken one per
// cycle as long as the two-entry command queue has room; the cursor is
// tracked in the front end, cell writes and clears are applied by the back
// end one per cycle while no update scan runs. An update scans the grid in
// row-major order through the single-port text and shadow memories, each
// cell in a read state, then a compare and shadow write state that an
// output stall can hold; each changed cell gives one result transaction,
// the final one flagged by last. Up to 64 results per update. No reset
// sweep: both memories come out of reset through per-cell valid flags.
`default_nettype none

module text_cell_diff_refresh import tcdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] start_col_i,
  input  logic [7:0] start_row_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] cell_col_o,
  output logic [1:0] cell_row_o,
  output logic [7:0] char_code_o,
  output logic [7:0] glyph_index_o,
  output logic [6:0] pixel_column_o,
  output logic [2:0] top_page_o,
  output logic       last_o
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  tcdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .start_col_i (start_col_i),
    .start_row_i (start_row_i),
    .char_in_i   (char_in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_wr_cmd)
  );

  tcdr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_rd_cmd)
  );

  tcdr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (q_rd_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_col_o     (cell_col_o),
    .cell_row_o     (cell_row_o),
    .char_code_o    (char_code_o),
    .glyph_index_o  (glyph_index_o),
    .pixel_column_o (pixel_column_o),
    .top_page_o     (top_page_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb_text_cell_diff_refresh.sv
`timescale 1ns / 1ps
// Testbench for text_cell_diff_refresh: queue-fed host driver, result monitor and
// an in-bench predictor of the text grid, shadow grid and cursor.
// Depends on tcdr_pkg and the text_cell_diff_refresh RTL.

module tb_text_cell_diff_refresh import tcdr_pkg::*;;

  typedef struct {
    kind_e      kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] ch;
  } host_item_t;

  typedef struct {
    logic [3:0] col;
    logic [1:0] row;
    logic [7:0] code;
    logic [7:0] glyph;
    logic [6:0] px;
    logic [2:0] page;
    logic       last;
  } cell_upd_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  kind_e      kind_i      = KIND_START;
  logic [7:0] start_col_i = 8'd0;
  logic [7:0] start_row_i = 8'd0;
  logic [7:0] char_in_i   = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] cell_col_o;
  logic [1:0] cell_row_o;
  logic [7:0] char_code_o;
  logic [7:0] glyph_index_o;
  logic [6:0] pixel_column_o;
  logic [2:0] top_page_o;
  logic       last_o;

  text_cell_diff_refresh DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_col_o     (cell_col_o),
    .cell_row_o     (cell_row_o),
    .char_code_o    (char_code_o),
    .glyph_index_o  (glyph_index_o),
    .pixel_column_o (pixel_column_o),
    .top_page_o     (top_page_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted grid, panel shadow and cursor
  logic [7:0] text_grid   [CELLS];
  logic [7:0] shadow_grid [CELLS];
  logic [7:0] cur_col, cur_row, line_col;

  host_item_t host_q[$];
  cell_upd_t  cell_upd_q[$];

  int unsigned fail_cnt    = 0;
  int unsigned queued_cnt  = 0;
  int unsigned host_cnt    = 0;
  int unsigned update_cnt  = 0;
  int unsigned cells_seen  = 0;

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic refresh_panel();
    int         n;
    bit         capped;
    int         idx;
    logic [7:0] ch;
    cell_upd_t  u;
    n      = 0;
    capped = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (!capped) begin
          idx = r * COLS + c;
          ch  = text_grid[idx];
          if (ch != shadow_grid[idx]) begin
            if (n >= MAX_RESULTS) begin
              capped = 1'b1;
            end else begin
              u.col   = 4'(c);
              u.row   = 2'(r);
              u.code  = ch;
              u.glyph = ch - SPACE_CODE;
              u.px    = 7'(c * 8);
              u.page  = 3'(r * 2);
              u.last  = 1'b0;
              cell_upd_q.push_back(u);
              n++;
            end
          end
          if (!capped) shadow_grid[idx] = ch;
        end
      end
    end
    if (n > 0) cell_upd_q[cell_upd_q.size() - 1].last = 1'b1;
  endtask

  task automatic apply_host_item(input host_item_t it);
    case (it.kind)
      KIND_START: begin
        cur_col  = it.col;
        line_col = it.col;
        cur_row  = it.row;
      end
      KIND_PUTC: begin
        if (it.ch == NEWLINE_CODE) begin
          cur_row = bump(cur_row);
          cur_col = line_col;
        end else if (it.ch != NUL_CODE) begin
          // off-grid characters are dropped but still move the cursor
          if (cur_col < COLS && cur_row < ROWS) text_grid[cur_row * COLS + cur_col] = it.ch;
          cur_col = bump(cur_col);
        end
      end
      KIND_CLEAR: begin
        foreach (text_grid[i]) text_grid[i] = SPACE_CODE;
      end
      default: begin
        update_cnt++;
        refresh_panel();
      end
    endcase
  endtask

  // host driver
  host_item_t  drv_item;
  int unsigned drv_gap   = 0;
  int unsigned drv_quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_gap    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_host_item(drv_item);
        host_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (host_q.size() > 0) begin
          drv_item = host_q.pop_front();
          kind_i      <= drv_item.kind;
          start_col_i <= drv_item.col;
          start_row_i <= drv_item.row;
          char_in_i   <= drv_item.ch;
          in_valid_i  <= 1'b1;
          if (drv_quiet > 0) begin
            drv_quiet--;
          end else begin
            drv_gap = pick_idle();
            if ($urandom_range(0, 19) == 0) drv_quiet = $urandom_range(15, 50);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  cell_upd_t   got_upd;
  int unsigned mon_stall = 0;
  int unsigned mon_quiet = 0;

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_stall = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cell_upd_q.size() == 0) begin
          $error("cell update with nothing pending: col %0d row %0d char %0d",
                 cell_col_o, cell_row_o, char_code_o);
          fail_cnt++;
        end else begin
          got_upd = cell_upd_q.pop_front();
          check_field("cell_col", got_upd.col, cell_col_o);
          check_field("cell_row", got_upd.row, cell_row_o);
          check_field("char_code", got_upd.code, char_code_o);
          check_field("glyph_index", got_upd.glyph, glyph_index_o);
          check_field("pixel_column", got_upd.px, pixel_column_o);
          check_field("top_page", got_upd.page, top_page_o);
          check_field("last", got_upd.last, last_o);
          cells_seen++;
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_stall_i <= 1'b1;
      end else if (mon_quiet > 0) begin
        mon_quiet--;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        mon_stall = pick_idle();
        if (mon_stall > 0) begin
          mon_stall--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 29) == 0) mon_quiet = $urandom_range(20, 80);
      end
    end
  end

  task automatic queue_host(input kind_e k, input logic [7:0] c, input logic [7:0] r,
                            input logic [7:0] ch);
    host_item_t it;
    it.kind = k;
    it.col  = c;
    it.row  = r;
    it.ch   = ch;
    host_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic queue_putc(input logic [7:0] ch);
    queue_host(KIND_PUTC, 8'($urandom), 8'($urandom), ch);
  endtask

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return NEWLINE_CODE;
    if (r < 14) return NUL_CODE;
    if (r < 80) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_drained();
    while (host_q.size() != 0 || in_valid_i || cell_upd_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sel;
    int unsigned len;
    bit          paused;
    foreach (text_grid[i]) text_grid[i] = SPACE_CODE;
    foreach (shadow_grid[i]) shadow_grid[i] = 8'h00;
    cur_col  = 8'd0;
    cur_row  = 8'd0;
    line_col = 8'd0;
    paused   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whole grid differs from the zeroed shadow, then nothing changed
    queue_host(KIND_UPDATE, 8'h00, 8'h00, 8'h00);
    queue_host(KIND_UPDATE, 8'hFF, 8'hFF, 8'hFF);
    queue_host(KIND_START, 8'd0, 8'd0, 8'hFF);
    queue_putc(8'h41);
    queue_putc(8'hFF);
    queue_putc(NUL_CODE);
    queue_putc(NEWLINE_CODE);
    queue_putc(8'h01);
    // last column, then dropped past the right edge
    queue_host(KIND_START, 8'd15, 8'd3, 8'h00);
    queue_putc(8'h7E);
    queue_putc(8'h80);
    // cursor saturation on both axes
    queue_host(KIND_START, 8'd254, 8'd255, 8'h00);
    queue_putc(8'h55);
    queue_putc(8'h55);
    queue_putc(8'h55);
    queue_putc(NEWLINE_CODE);
    queue_host(KIND_UPDATE, 8'h00, 8'h00, 8'h00);
    // row below the grid
    queue_host(KIND_START, 8'd2, 8'd4, 8'h00);
    queue_putc(8'h33);
    queue_host(KIND_CLEAR, 8'hA5, 8'h5A, 8'hC3);
    queue_host(KIND_UPDATE, 8'h00, 8'h00, 8'h00);
    queue_host(KIND_START, 8'd8, 8'd1, 8'h00);
    queue_putc(8'h20);
    queue_putc(8'h21);
    queue_host(KIND_UPDATE, 8'h00, 8'h00, 8'h00);

    while (queued_cnt < 212) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        queue_host(KIND_START, 8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, ROWS - 1)),
                   8'($urandom));
        len = $urandom_range(1, 12);
        repeat (len) queue_putc(rand_char());
        if ($urandom_range(0, 1) == 0) queue_host(KIND_UPDATE, 8'($urandom), 8'($urandom),
                                                  8'($urandom));
      end else if (sel < 80) begin
        queue_host(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) == 0) queue_putc(rand_char());
        queue_host(KIND_UPDATE, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 90) begin
        queue_host(KIND_START, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 3)) queue_putc(8'($urandom));
      end else begin
        queue_host(KIND_UPDATE, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      // hold the host off once until the panel has caught up
      if (!paused && queued_cnt > 120) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    queue_host(KIND_UPDATE, 8'h00, 8'h00, 8'h00);

    wait_drained();
    repeat (2 * CELLS + 64) @(posedge clk_i);
    $display("tb: %0d host transactions accepted, %0d of them updates", host_cnt, update_cnt);
    $display("tb: %0d changed-cell transactions checked against the predicted grid", cells_seen);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
